// ----- src/mwma_pkg.sv -----
package mwma_pkg;

	localparam int LOAD_W     = 14;
	localparam int SUM_W      = 18;
	localparam int HELD_W     = 4;
	localparam int COUNT_W    = 64;
	localparam int RING_DEPTH = 15;
	localparam int STATUS_W   = 2;

	localparam logic [LOAD_W-1:0] LOAD_MAX = 14'd10000;
	localparam logic [HELD_W-1:0] HELD_MAX = 4'd15;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// stage enables shared by the window units
	typedef struct packed {
		logic upd;
		logic adv1;
		logic adv2;
	} mwma_ctl_t;

endpackage

// ----- src/multi_window_moving_average_unit.sv -----
// Moving averages of a load stream over three windows (SHORT_WINDOW, MID_WINDOW,
// LONG_WINDOW samples, each 1..15). One sample beat can be taken every clock cycle
// unless the result side stalls; each beat gives one result beat, registered after
// the running-sum update and again after the reciprocal multiply that divides each
// sum by its window. Samples sit in a 15-cell shift chain; cell W-1 feeds the
// sample leaving window W. Samples above 10000 and samples arriving with the
// 64-bit count saturated are reported through status and leave the state untouched.
module multi_window_moving_average_unit #(
	parameter int SHORT_WINDOW = 5,
	parameter int MID_WINDOW   = 10,
	parameter int LONG_WINDOW  = 15
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,  // [13:0] load_hundredths
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,  // [13:0] short_average, [27:14] mid_average,
	                               // [41:28] long_average, [105:42] accepted_count
	output logic [4:0]   m_tuser   // [0] short_ready, [1] mid_ready, [2] long_ready,
	                               // [4:3] status
);
	import mwma_pkg::*;

	logic [LOAD_W-1:0]   sample;
	logic                accept;
	logic [STATUS_W-1:0] status_nx;
	mwma_ctl_t           ctl;

	logic                v1_q, v2_q;
	logic [HELD_W-1:0]   held_q, held_nx, held_s1;
	logic [COUNT_W-1:0]  total_q, total_nx, count_s1, count_s2;
	logic [STATUS_W-1:0] status_s1, status_s2;

	logic [LOAD_W-1:0] cell_q [RING_DEPTH];

	logic [LOAD_W-1:0] short_avg, mid_avg, long_avg;
	logic              short_rdy, mid_rdy, long_rdy;

	assign sample = s_tdata[LOAD_W-1:0];

	assign ctl.adv2 = !v2_q || m_tready;
	assign ctl.adv1 = !v1_q || ctl.adv2;
	assign s_tready = ctl.adv1;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (sample > LOAD_MAX) begin
			status_nx = STATUS_RANGE;
		end else if (total_q == '1) begin
			status_nx = STATUS_FULL;
		end else begin
			status_nx = STATUS_OK;
		end
	end

	assign ctl.upd  = accept && (status_nx == STATUS_OK);
	assign held_nx  = held_q + HELD_W'(held_q != HELD_MAX);
	assign total_nx = total_q + COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			total_q <= '0;
		end else if (ctl.upd) begin
			held_q  <= held_nx;
			total_q <= total_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (ctl.adv1) begin
				v1_q <= accept;
			end
			if (ctl.adv2) begin
				v2_q <= v1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv1) begin
			held_s1   <= ctl.upd ? held_nx : held_q;
			count_s1  <= ctl.upd ? total_nx : total_q;
			status_s1 <= status_nx;
		end
		if (ctl.adv2) begin
			count_s2  <= count_s1;
			status_s2 <= status_s1;
		end
	end

	// newest sample in cell 0
	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			mwma_cell u_cell (.clk(clk), .shift(ctl.upd), .d(sample), .q(cell_q[i]));
		end else begin : g_body
			mwma_cell u_cell (.clk(clk), .shift(ctl.upd), .d(cell_q[i-1]), .q(cell_q[i]));
		end
	end

	mwma_window #(.Window(SHORT_WINDOW)) u_short (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sample(sample),
		.leaving(cell_q[SHORT_WINDOW-1]), .held(held_q), .held_s1(held_s1),
		.average(short_avg), .ready(short_rdy)
	);

	mwma_window #(.Window(MID_WINDOW)) u_mid (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sample(sample),
		.leaving(cell_q[MID_WINDOW-1]), .held(held_q), .held_s1(held_s1),
		.average(mid_avg), .ready(mid_rdy)
	);

	mwma_window #(.Window(LONG_WINDOW)) u_long (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sample(sample),
		.leaving(cell_q[LONG_WINDOW-1]), .held(held_q), .held_s1(held_s1),
		.average(long_avg), .ready(long_rdy)
	);

	assign m_tvalid = v2_q;
	assign m_tdata  = {6'd0, count_s2, long_avg, mid_avg, short_avg};
	assign m_tuser  = {status_s2, long_rdy, mid_rdy, short_rdy};

`ifndef SYNTH
	a_held_tracks_total: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == ((total_q > 64'd15) ? HELD_MAX : total_q[HELD_W-1:0]))
		else $error("held count out of step with accepted total");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd |=> total_q == $past(total_q) + 64'd1)
		else $error("accepted total did not advance by one");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && v2_q && !m_tready) |-> !s_tready)
		else $error("input taken while both stages are stalled");

	a_reject_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status_nx != STATUS_OK) |=> $stable(total_q) && $stable(held_q))
		else $error("rejected sample changed the state");
`endif

endmodule

// ----- src/mwma_cell.sv -----
module mwma_cell (
	input  logic                       clk,
	input  logic                       shift,
	input  logic [mwma_pkg::LOAD_W-1:0] d,
	output logic [mwma_pkg::LOAD_W-1:0] q
);
	import mwma_pkg::*;

	logic [LOAD_W-1:0] sample_q;

	// only read once written, so no reset
	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

// ----- src/mwma_window.sv -----
module mwma_window #(
	parameter int Window = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mwma_pkg::mwma_ctl_t         ctl,
	input  logic [mwma_pkg::LOAD_W-1:0] sample,
	input  logic [mwma_pkg::LOAD_W-1:0] leaving,
	input  logic [mwma_pkg::HELD_W-1:0] held,
	input  logic [mwma_pkg::HELD_W-1:0] held_s1,
	output logic [mwma_pkg::LOAD_W-1:0] average,
	output logic                        ready
);
	import mwma_pkg::*;

	// floor(x / Window) == (x * Recip) >> RecipShift for x < 2**SUM_W
	localparam int RecipShift = SUM_W + 4;
	localparam int RecipW     = RecipShift + 1;
	localparam int ProdW      = SUM_W + RecipW;
	localparam logic [RecipW-1:0] Recip =
		RecipW'(((64'd1 << RecipShift) + 64'(Window) - 64'd1) / 64'(Window));

	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_nx;
	logic [SUM_W-1:0]  sum_s1;
	logic [ProdW-1:0]  prod;
	logic              ready_nx;
	logic [LOAD_W-1:0] avg_s2;
	logic              ready_s2;

	assign sum_nx = sum_q
		- ((held >= HELD_W'(Window)) ? SUM_W'(leaving) : '0)
		+ SUM_W'(sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.upd) begin
			sum_q <= sum_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv1) begin
			sum_s1 <= ctl.upd ? sum_nx : sum_q;
		end
	end

	assign prod     = ProdW'(sum_s1) * ProdW'(Recip);
	assign ready_nx = held_s1 >= HELD_W'(Window);

	always_ff @(posedge clk) begin
		if (ctl.adv2) begin
			avg_s2   <= ready_nx ? prod[RecipShift +: LOAD_W] : '0;
			ready_s2 <= ready_nx;
		end
	end

	assign average = avg_s2;
	assign ready   = ready_s2;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import mwma_pkg::*;

	localparam int SHORT_SPAN    = 5;
	localparam int MID_SPAN      = 10;
	localparam int LONG_SPAN     = 15;
	localparam int RANDOM_ITEMS  = 800;
	localparam int HOLD_CYCLES   = 150;
	localparam int STALL_LIMIT   = 2000;

	typedef struct {
		logic [LOAD_W-1:0]   short_avg;
		logic                short_rdy;
		logic [LOAD_W-1:0]   mid_avg;
		logic                mid_rdy;
		logic [LOAD_W-1:0]   long_avg;
		logic                long_rdy;
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] status;
	} averages_t;

	class window_average_tracker;
		logic [LOAD_W-1:0] ring [RING_DEPTH];
		int                slot;
		int                held;
		int                short_sum;
		int                mid_sum;
		int                long_sum;
		logic [COUNT_W-1:0] total;
		averages_t         expected_averages [$];
		int                errors;
		int                taken_ok;
		int                taken_range;
		int                checked;

		function new();
			foreach (ring[k]) ring[k] = '0;
			slot = 0;
			held = 0;
			short_sum = 0;
			mid_sum = 0;
			long_sum = 0;
			total = '0;
			errors = 0;
			taken_ok = 0;
			taken_range = 0;
			checked = 0;
		endfunction

		// sum after the sample leaving a window of span w is dropped and the new one added
		function int slide(int sum, int w, int load);
			if (held >= w)
				sum -= int'(ring[(slot + RING_DEPTH - w) % RING_DEPTH]);
			return sum + load;
		endfunction

		function void note_sample(logic [LOAD_W-1:0] load);
			averages_t e;
			if (load > LOAD_MAX) begin
				e.status = STATUS_RANGE;
				taken_range++;
			end else if (&total) begin
				// saturated count: not reachable in a run of this length
				e.status = STATUS_FULL;
			end else begin
				e.status = STATUS_OK;
				short_sum = slide(short_sum, SHORT_SPAN, int'(load));
				mid_sum = slide(mid_sum, MID_SPAN, int'(load));
				long_sum = slide(long_sum, LONG_SPAN, int'(load));
				ring[slot] = load;
				slot = (slot + 1) % RING_DEPTH;
				if (held < RING_DEPTH)
					held++;
				total++;
				taken_ok++;
			end
			e.short_rdy = (held >= SHORT_SPAN);
			e.mid_rdy = (held >= MID_SPAN);
			e.long_rdy = (held >= LONG_SPAN);
			e.short_avg = e.short_rdy ? LOAD_W'(short_sum / SHORT_SPAN) : '0;
			e.mid_avg = e.mid_rdy ? LOAD_W'(mid_sum / MID_SPAN) : '0;
			e.long_avg = e.long_rdy ? LOAD_W'(long_sum / LONG_SPAN) : '0;
			e.count = total;
			expected_averages.push_back(e);
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_result(logic [111:0] data, logic [4:0] user);
			averages_t e;
			if (expected_averages.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, tdata %h tuser %h",
					$time, data, user);
				return;
			end
			e = expected_averages.pop_front();
			checked++;
			compare("short_average", 64'(e.short_avg), 64'(data[13:0]));
			compare("mid_average", 64'(e.mid_avg), 64'(data[27:14]));
			compare("long_average", 64'(e.long_avg), 64'(data[41:28]));
			compare("accepted_count", e.count, data[105:42]);
			compare("pad", 64'd0, 64'(data[111:106]));
			compare("short_ready", 64'(e.short_rdy), 64'(user[0]));
			compare("mid_ready", 64'(e.mid_rdy), 64'(user[1]));
			compare("long_ready", 64'(e.long_rdy), 64'(user[2]));
			compare("status", 64'(e.status), 64'(user[4:3]));
		endfunction

		function int outstanding();
			return expected_averages.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;
	logic [4:0]   m_tuser;

	window_average_tracker tracker = new();
	bit back_to_back = 1'b0;
	int idle_cycles = 0;

	int unsigned directed_loads [25] = '{
		10001, 16383, 10000, 0, 1, 9999, 10000, 8191, 12345, 8192,
		10000, 10000, 10000, 10000, 10000, 10000, 10000, 10000, 10000, 10000,
		10000, 0, 10001, 0, 0
	};

	multi_window_moving_average_unit #(
		.SHORT_WINDOW(SHORT_SPAN),
		.MID_WINDOW(MID_SPAN),
		.LONG_WINDOW(LONG_SPAN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	// handshakes are decided by the values held between the falling and the next rising edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_sample(s_tdata[LOAD_W-1:0]);
			if (m_tvalid && m_tready)
				tracker.check_result(m_tdata, m_tuser);
		end
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [LOAD_W-1:0] draw_load();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return LOAD_W'($urandom_range(10001, 16383));
		else if (pick < 13)
			return LOAD_MAX;
		else if (pick < 16)
			return '0;
		else
			return LOAD_W'($urandom_range(0, 10000));
	endfunction

	task send_sample(input logic [LOAD_W-1:0] load, input int gap);
		logic took;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, load};
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
	endtask

	// result side: random stalls, one long hold so the block backs up into its input
	initial begin
		int stall;
		int taken;
		logic got;
		taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = back_to_back ? 0 : $urandom_range(0, 13);
			if (taken == 400)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				got = m_tvalid;
				@(posedge clk);
			end while (!got);
			taken++;
		end
	end

	initial begin
		int i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_loads[k])
			send_sample(LOAD_W'(directed_loads[k]), $urandom_range(0, 13));

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			back_to_back = (i >= 200 && i < 300);
			send_sample(draw_load(), back_to_back ? 0 : $urandom_range(0, 13));
		end
		s_tvalid <= 1'b0;

		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d samples: %0d taken into the windows, %0d rejected as out of range.",
			tracker.taken_ok + tracker.taken_range, tracker.taken_ok, tracker.taken_range);
		$display("Checked %0d result beats, including a back-to-back burst and a long output hold.",
			tracker.checked);
		if (tracker.errors == 0 && tracker.outstanding() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
